// ===== sv/sct_pkg.sv =====
// ----------------------------------------------------------------------------
// sct_pkg : shared types and constants for the spectral channel tracker
// Request and outcome codes, register indexes and the slot sequencer states.
// ----------------------------------------------------------------------------
package sct_pkg;

   localparam int MaxSlots  = 16;
   localparam int FreqBits  = 21;
   localparam int SlotBits  = 4;
   localparam int CountBits = 5;

   typedef enum logic [1:0] {
      REQ_PEAK   = 2'd0,
      REQ_TICK   = 2'd1,
      REQ_NOTICE = 2'd2,
      REQ_CLEAR  = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      OUT_UPDATED = 3'd0,
      OUT_CREATED = 3'd1,
      OUT_BAND    = 3'd2,
      OUT_FULL    = 3'd3,
      OUT_TICK    = 3'd4,
      OUT_NOTED   = 3'd5,
      OUT_UNKNOWN = 3'd6,
      OUT_CLEARED = 3'd7
   } outcome_type;

   localparam logic [2:0] REG_CENTER   = 3'd0;
   localparam logic [2:0] REG_BAND_LO  = 3'd1;
   localparam logic [2:0] REG_BAND_HI  = 3'd2;
   localparam logic [2:0] REG_SPACING  = 3'd3;
   localparam logic [2:0] REG_LIMIT    = 3'd4;
   localparam logic [2:0] REG_LOSS     = 3'd5;
   localparam logic [2:0] REG_TIMEOUT  = 3'd6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY,
      ST_OUT
   } state_type;

endpackage

// ===== sv/sct_core.sv =====
// ----------------------------------------------------------------------------
// sct_core : slot table and sequencer
// Walks one slot per cycle through a shared compare unit, then applies.
// ----------------------------------------------------------------------------
module sct_core import sct_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [1:0]  kind,
   input  logic signed [FreqBits-1:0] freq,
   input  logic [13:0] bin,
   input  logic [31:0] magnitude,
   input  logic [15:0] snr,
   input  logic [31:0] notice_id,
   input  logic [31:0] center_hz,
   input  logic [31:0] band_lo_hz,
   input  logic [31:0] band_hi_hz,
   input  logic [15:0] spacing,
   input  logic [4:0]  limit,
   input  logic [15:0] loss_s,
   input  logic [15:0] timeout_s,
   output logic        busy,
   output logic        done,
   output logic [2:0]  outcome,
   output logic [3:0]  slot,
   output logic [31:0] chan_id,
   output logic [4:0]  in_use,
   output logic [4:0]  removed,
   output logic [15:0] sig_mask
);

   state_type state_ff, state_in;
   logic [SlotBits-1:0] idx_ff, idx_in;
   logic [MaxSlots-1:0] valid_ff, valid_in, sig_ff, sig_in;
   logic [31:0] id_mem     [MaxSlots];
   logic [FreqBits-1:0] cen_mem [MaxSlots];
   logic [13:0] bin_mem    [MaxSlots];
   logic [15:0] snr_mem    [MaxSlots];
   logic [31:0] lvl_mem    [MaxSlots];
   logic [31:0] seen_mem   [MaxSlots];
   logic [31:0] dec_mem    [MaxSlots];
   logic [31:0] now_ff, now_in, next_id_ff, next_id_in;
   logic        hit_ff, hit_in, free_ff, free_in;
   logic [SlotBits-1:0] best_ff, best_in, free_idx_ff, free_idx_in;
   logic [4:0]  cnt_ff, cnt_in, rem_ff, rem_in;
   logic [2:0]  out_ff, out_in;
   logic [3:0]  slot_ff, slot_in;
   logic [31:0] cid_ff, cid_in;
   logic        band_ok;
   logic signed [33:0] absf;
   logic signed [FreqBits:0] d, ad;
   logic        cmp_hit, last;
   logic [4:0]  lim;
   logic [31:0] now1;

   assign absf = $signed({2'b00, center_hz}) + 34'(freq);
   assign band_ok = (absf >= $signed({2'b00, band_lo_hz}))
                 && (absf <= $signed({2'b00, band_hi_hz}));
   assign d  = $signed({cen_mem[idx_ff][FreqBits-1], cen_mem[idx_ff]})
             - $signed({freq[FreqBits-1], freq});
   assign ad = d[FreqBits] ? -d : d;
   assign last = (idx_ff == SlotBits'(MaxSlots-1));
   assign lim = (limit > 5'(MaxSlots)) ? 5'(MaxSlots) : limit;
   assign now1 = now_ff + 32'd1;

   always_comb begin
      cmp_hit = 1'b0;
      case (kind)
         REQ_PEAK:   cmp_hit = valid_ff[idx_ff]
                        && ({ad[FreqBits-1:0], 1'b0} < (FreqBits+1)'(spacing));
         REQ_NOTICE: cmp_hit = valid_ff[idx_ff] && (id_mem[idx_ff] == notice_id);
         default:    cmp_hit = 1'b0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (start) state_in = ST_SCAN;
         ST_SCAN:  if (last) state_in = ST_APPLY;
         ST_APPLY: state_in = ST_OUT;
         ST_OUT:   state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      idx_in = idx_ff; hit_in = hit_ff; best_in = best_ff; free_in = free_ff;
      free_idx_in = free_idx_ff; cnt_in = cnt_ff; rem_in = rem_ff;
      valid_in = valid_ff; sig_in = sig_ff; now_in = now_ff;
      next_id_in = next_id_ff; out_in = out_ff; slot_in = slot_ff; cid_in = cid_ff;
      case (state_ff)
         ST_IDLE: begin
            idx_in = '0; hit_in = 1'b0; free_in = 1'b0; cnt_in = '0; rem_in = '0;
            if (start && kind == REQ_TICK) now_in = now1;
         end
         ST_SCAN: begin
            idx_in = idx_ff + 1'b1;
            if (valid_ff[idx_ff]) cnt_in = cnt_ff + 5'd1;
            else if (!free_ff) begin
               free_in = 1'b1; free_idx_in = idx_ff;
            end
            if (cmp_hit && (!hit_ff || (kind == REQ_PEAK
                  && id_mem[idx_ff] < id_mem[best_ff]))) begin
               hit_in = 1'b1; best_in = idx_ff;
            end
            if (kind == REQ_TICK && valid_ff[idx_ff]) begin
               if ((now_ff - seen_mem[idx_ff]) > {16'd0, loss_s}) sig_in[idx_ff] = 1'b0;
               if ((now_ff - dec_mem[idx_ff]) > {16'd0, timeout_s}) begin
                  valid_in[idx_ff] = 1'b0; sig_in[idx_ff] = 1'b0;
                  rem_in = rem_ff + 5'd1; cnt_in = cnt_ff;
               end
            end
         end
         ST_APPLY: begin
            slot_in = '0; cid_in = '0;
            case (kind)
               REQ_PEAK: begin
                  if (!band_ok) out_in = OUT_BAND;
                  else if (hit_ff) begin
                     out_in = OUT_UPDATED; slot_in = best_ff; cid_in = id_mem[best_ff];
                     sig_in[best_ff] = 1'b1;
                  end else if (cnt_ff >= lim || !free_ff) out_in = OUT_FULL;
                  else begin
                     out_in = OUT_CREATED; slot_in = free_idx_ff; cid_in = next_id_ff;
                     valid_in[free_idx_ff] = 1'b1; sig_in[free_idx_ff] = 1'b1;
                     next_id_in = next_id_ff + 32'd1; cnt_in = cnt_ff + 5'd1;
                  end
               end
               REQ_TICK: out_in = OUT_TICK;
               REQ_NOTICE: begin
                  cid_in = notice_id;
                  if (hit_ff) begin
                     out_in = OUT_NOTED; slot_in = best_ff;
                  end else out_in = OUT_UNKNOWN;
               end
               default: begin
                  out_in = OUT_CLEARED; valid_in = '0; sig_in = '0;
                  next_id_in = 32'd1; cnt_in = '0;
               end
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; valid_ff <= '0; sig_ff <= '0;
         now_ff <= '0; next_id_ff <= 32'd1;
      end else begin
         state_ff <= state_in; valid_ff <= valid_in; sig_ff <= sig_in;
         now_ff <= now_in; next_id_ff <= next_id_in;
      end
      idx_ff <= idx_in; hit_ff <= hit_in; best_ff <= best_in; free_ff <= free_in;
      free_idx_ff <= free_idx_in; cnt_ff <= cnt_in; rem_ff <= rem_in;
      out_ff <= out_in; slot_ff <= slot_in; cid_ff <= cid_in;
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_APPLY) begin
         if (kind == REQ_PEAK && band_ok && (hit_ff || (cnt_ff < lim && free_ff))) begin
            if (hit_ff) begin
               cen_mem[best_ff] <= freq; bin_mem[best_ff] <= bin;
               snr_mem[best_ff] <= snr; lvl_mem[best_ff] <= magnitude;
               seen_mem[best_ff] <= now_ff;
            end else begin
               id_mem[free_idx_ff] <= next_id_ff; cen_mem[free_idx_ff] <= freq;
               bin_mem[free_idx_ff] <= bin; snr_mem[free_idx_ff] <= snr;
               lvl_mem[free_idx_ff] <= magnitude; seen_mem[free_idx_ff] <= now_ff;
               dec_mem[free_idx_ff] <= now_ff;
            end
         end
         if (kind == REQ_NOTICE && hit_ff) dec_mem[best_ff] <= now_ff;
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign done = (state_ff == ST_OUT);
   assign outcome = out_ff;
   assign slot = slot_ff;
   assign chan_id = cid_ff;
   assign in_use = cnt_ff;
   assign removed = rem_ff;
   assign sig_mask = sig_ff;

endmodule

// ===== sv/spectral_channel_tracker.sv =====
// ----------------------------------------------------------------------------
// spectral_channel_tracker : table of tracked narrowband channels
// Usage:
//   req_ beats carry a peak, a one-second tick, a decode notice or a clear.
//   Each accepted beat yields exactly one rsp_ beat.
//   The slot walk takes one slot per cycle through a shared compare unit;
//   an item passes start, scan, apply and out before rsp_tvalid rises.
//   req_tready is low while an item is in work or its result waits.
//   The result register holds while rsp_tready is low.
//   csr_ writes take effect at once; write only while idle.
//   Reset (synchronous, high) empties the table, sets time to 0 and the
//   next id to 1, and restores register defaults.
//   A new item is taken only once the previous result has left on rsp_,
//   so items do not overlap and a stall on rsp_tready holds the next one.
// ----------------------------------------------------------------------------
module spectral_channel_tracker import sct_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,   // req_type
   // peak_freq_hz[20:0], peak_bin[34:21], peak_magnitude[66:35],
   // peak_snr_db[82:67], notice_id[114:83]
   input  logic [119:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [2:0]   rsp_tuser,   // outcome
   // slot[3:0], chan_id[35:4], channels_in_use[40:36],
   // removed_count[45:41], signal_mask[61:46]
   output logic [63:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   logic [31:0] center_ff, lo_ff, hi_ff;
   logic [15:0] spacing_ff, loss_ff, timeout_ff;
   logic [4:0]  limit_ff;
   logic [1:0]  kind_ff;
   logic [119:0] data_ff;
   logic        rvalid_ff, start;
   logic        busy, done;
   logic [2:0]  outcome;
   logic [3:0]  slot;
   logic [31:0] cid;
   logic [4:0]  in_use, removed;
   logic [15:0] sig_mask;
   logic [2:0]  ruser_ff;
   logic [63:0] rdata_ff;

   assign req_tready = !busy && !rvalid_ff && !start;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= 32'd14035000; lo_ff <= 32'd14000000; hi_ff <= 32'd14070000;
         spacing_ff <= 16'd100; limit_ff <= 5'd16; loss_ff <= 16'd5;
         timeout_ff <= 16'd30;
      end else if (csr_we) begin
         case (csr_index)
            REG_CENTER:  center_ff  <= csr_wdata;
            REG_BAND_LO: lo_ff      <= csr_wdata;
            REG_BAND_HI: hi_ff      <= csr_wdata;
            REG_SPACING: spacing_ff <= csr_wdata[15:0];
            REG_LIMIT:   limit_ff   <= csr_wdata[4:0];
            REG_LOSS:    loss_ff    <= csr_wdata[15:0];
            REG_TIMEOUT: timeout_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start <= 1'b0; rvalid_ff <= 1'b0;
      end else begin
         start <= req_tvalid && req_tready;
         if (done) rvalid_ff <= 1'b1;
         else if (rsp_tready) rvalid_ff <= 1'b0;
      end
      if (req_tvalid && req_tready) begin
         kind_ff <= req_tuser; data_ff <= req_tdata;
      end
      if (done) begin
         ruser_ff <= outcome;
         rdata_ff <= {2'b00, sig_mask, removed, in_use, cid, slot};
      end
   end

   sct_core u_core (
      .clock(clock), .reset(reset), .start(start), .kind(kind_ff),
      .freq(data_ff[20:0]), .bin(data_ff[34:21]), .magnitude(data_ff[66:35]),
      .snr(data_ff[82:67]), .notice_id(data_ff[114:83]),
      .center_hz(center_ff), .band_lo_hz(lo_ff), .band_hi_hz(hi_ff),
      .spacing(spacing_ff), .limit(limit_ff), .loss_s(loss_ff),
      .timeout_s(timeout_ff), .busy(busy), .done(done), .outcome(outcome),
      .slot(slot), .chan_id(cid), .in_use(in_use), .removed(removed),
      .sig_mask(sig_mask)
   );

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tuser  = ruser_ff;
   assign rsp_tdata  = rdata_ff;

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench : self-checking bench for spectral_channel_tracker
// Drives peaks, ticks, decode notices and clears through the req_ stream,
// predicts every rsp_ beat with a behavioral copy of the channel table and
// compares it field by field. Walks several register settings, extremes too.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import sct_pkg::*;

   typedef struct packed {
      outcome_type outcome;
      logic [3:0]  slot;
      logic [31:0] chan_id;
      logic [4:0]  in_use;
      logic [4:0]  removed;
      logic [15:0] mask;
   } tracker_rsp_type;

   typedef struct {
      req_kind_type kind;
      logic [20:0]  freq;
      logic [13:0]  bin;
      logic [31:0]  mag;
      logic [15:0]  snr;
      logic [31:0]  id;
      logic         known;
      outcome_type  outcome;
      logic [4:0]   in_use;
   } step_row_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [1:0]   req_tuser;
   logic [119:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [2:0]   rsp_tuser;
   logic [63:0]  rsp_tdata;
   logic         csr_we;
   logic [2:0]   csr_index;
   logic [31:0]  csr_wdata;

   // model of the channel table
   logic [31:0] cfg_center, cfg_band_lo, cfg_band_hi;
   logic [15:0] cfg_spacing, cfg_loss, cfg_timeout;
   logic [4:0]  cfg_limit;
   logic        ch_valid [MaxSlots];
   logic        ch_signal [MaxSlots];
   logic [31:0] ch_id [MaxSlots];
   logic [20:0] ch_center [MaxSlots];
   logic [31:0] ch_seen [MaxSlots];
   logic [31:0] ch_decode [MaxSlots];
   logic [31:0] now_s;
   logic [31:0] next_chan_id;

   tracker_rsp_type pending_rsp[$];
   int errors;

   spectral_channel_tracker i_dut (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("[spectral_channel_tracker] ERROR");
      $finish;
   end

   function automatic int in_use_count();
      int n;
      n = 0;
      for (int i = 0; i < MaxSlots; i++) n += ch_valid[i];
      return n;
   endfunction

   function automatic logic [15:0] signal_bits();
      logic [15:0] m;
      for (int i = 0; i < MaxSlots; i++) m[i] = ch_signal[i];
      return m;
   endfunction

   function automatic tracker_rsp_type track_step(req_kind_type kind, logic [20:0] freq,
                                                  logic [31:0] id);
      tracker_rsp_type r;
      longint f, absf, d;
      int best, n;
      r = '0;
      case (kind)
         REQ_PEAK: begin
            f = longint'($signed(freq));
            absf = longint'(cfg_center) + f;
            if (absf < longint'(cfg_band_lo) || absf > longint'(cfg_band_hi)) begin
               r.outcome = OUT_BAND;
            end else begin
               best = -1;
               for (int i = 0; i < MaxSlots; i++) begin
                  if (ch_valid[i]) begin
                     d = longint'($signed(ch_center[i])) - f;
                     if (d < 0) d = -d;
                     if (2 * d < longint'(cfg_spacing) &&
                         (best < 0 || ch_id[i] < ch_id[best])) best = i;
                  end
               end
               r.outcome = OUT_UPDATED;
               if (best < 0) begin
                  n = in_use_count();
                  if (n >= ((cfg_limit > MaxSlots) ? MaxSlots : cfg_limit)) begin
                     r.outcome = OUT_FULL;
                  end else begin
                     for (int i = MaxSlots - 1; i >= 0; i--) if (!ch_valid[i]) best = i;
                     ch_valid[best] = 1'b1;
                     ch_id[best] = next_chan_id;
                     next_chan_id++;
                     ch_decode[best] = now_s;
                     r.outcome = OUT_CREATED;
                  end
               end
               if (r.outcome != OUT_FULL) begin
                  ch_center[best] = freq;
                  ch_signal[best] = 1'b1;
                  ch_seen[best] = now_s;
                  r.slot = best[3:0];
                  r.chan_id = ch_id[best];
               end
            end
         end
         REQ_TICK: begin
            now_s++;
            for (int i = 0; i < MaxSlots; i++) begin
               if (ch_valid[i]) begin
                  if (now_s - ch_seen[i] > {16'd0, cfg_loss}) ch_signal[i] = 1'b0;
                  if (now_s - ch_decode[i] > {16'd0, cfg_timeout}) begin
                     ch_valid[i] = 1'b0;
                     ch_signal[i] = 1'b0;
                     r.removed++;
                  end
               end
            end
            r.outcome = OUT_TICK;
         end
         REQ_NOTICE: begin
            best = -1;
            for (int i = MaxSlots - 1; i >= 0; i--)
               if (ch_valid[i] && ch_id[i] == id) best = i;
            r.outcome = OUT_UNKNOWN;
            if (best >= 0) begin
               ch_decode[best] = now_s;
               r.outcome = OUT_NOTED;
               r.slot = best[3:0];
            end
            r.chan_id = id;
         end
         default: begin
            for (int i = 0; i < MaxSlots; i++) begin
               ch_valid[i] = 1'b0;
               ch_signal[i] = 1'b0;
            end
            next_chan_id = 1;
            r.outcome = OUT_CLEARED;
         end
      endcase
      r.in_use = 5'(in_use_count());
      r.mask = signal_bits();
      return r;
   endfunction

   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_CENTER:  cfg_center = value;
         REG_BAND_LO: cfg_band_lo = value;
         REG_BAND_HI: cfg_band_hi = value;
         REG_SPACING: cfg_spacing = value[15:0];
         REG_LIMIT:   cfg_limit = value[4:0];
         REG_LOSS:    cfg_loss = value[15:0];
         default:     cfg_timeout = value[15:0];
      endcase
   endtask

   task automatic wait_drained();
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (25) @(posedge clock);
   endtask

   // one beat; a burst keeps tvalid high between beats
   task automatic send_beat(req_kind_type kind, logic [20:0] freq, logic [13:0] bin,
                            logic [31:0] mag, logic [15:0] snr, logic [31:0] id,
                            logic keep_valid, output tracker_rsp_type predicted);
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {5'd0, id, snr, mag, bin, freq};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = track_step(kind, freq, id);
      pending_rsp = {pending_rsp, predicted};
      if (!keep_valid) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // random item: mostly peaks, most within 200 of the center; else tick, notice or clear
   task automatic random_item(logic keep_valid);
      tracker_rsp_type p;
      int sel;
      logic [20:0] fq;
      logic [31:0] nid;
      req_kind_type k;
      sel = $urandom_range(99);
      fq = 21'($urandom);
      if (sel < 60) begin
         k = REQ_PEAK;
         if ($urandom_range(3) != 0) fq = 21'($signed($urandom_range(400)) - 200);
      end else if (sel < 82) k = REQ_TICK;
      else if (sel < 97) k = REQ_NOTICE;
      else k = REQ_CLEAR;
      nid = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(40));
      send_beat(k, fq, 14'($urandom), $urandom, 16'($urandom), nid, keep_valid, p);
   endtask

   // receiver with its own stall pattern
   initial begin
      tracker_rsp_type got, want;
      int stall_phase;
      rsp_tready = 1'b0;
      stall_phase = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.outcome = outcome_type'(rsp_tuser);
            got.slot = rsp_tdata[3:0];
            got.chan_id = rsp_tdata[35:4];
            got.in_use = rsp_tdata[40:36];
            got.removed = rsp_tdata[45:41];
            got.mask = rsp_tdata[61:46];
            if (pending_rsp.size() == 0) begin
               $display("%0t: unexpected beat %h", $time, got);
               errors++;
            end else begin
               want = pending_rsp.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch expected %p actual %p", $time, want, got);
                  errors++;
               end
            end
         end
         stall_phase = (stall_phase + 1) % 64;
         rsp_tready <= (stall_phase < 24) ? 1'b1 : ($urandom_range(3) != 0);
      end
   end

   step_row_type directed [] = '{
      '{REQ_NOTICE, 0, 0, 0, 0, 32'd1, 1, OUT_UNKNOWN, 0},
      '{REQ_PEAK, 21'h100000, 0, 0, 16'h8000, 0, 1, OUT_BAND, 0},
      '{REQ_PEAK, 21'h0FFFFF, 14'h3FFF, 32'hFFFFFFFF, 16'h7FFF, 0, 1, OUT_BAND, 0},
      '{REQ_PEAK, 21'd0, 14'h3FFF, 32'hFFFFFFFF, 16'h7FFF, 0, 1, OUT_CREATED, 1},
      '{REQ_PEAK, 21'd49, 0, 0, 16'h8000, 0, 1, OUT_UPDATED, 1},
      '{REQ_PEAK, 21'd150, 0, 0, 0, 0, 1, OUT_CREATED, 2},
      '{REQ_PEAK, -21'sd35000, 0, 0, 0, 0, 1, OUT_CREATED, 3},
      '{REQ_PEAK, 21'd35000, 0, 0, 0, 0, 1, OUT_CREATED, 4},
      '{REQ_PEAK, 21'd35001, 0, 0, 0, 0, 1, OUT_BAND, 4},
      '{REQ_PEAK, 21'd25, 0, 0, 0, 0, 0, OUT_UPDATED, 4},
      '{REQ_NOTICE, 0, 0, 0, 0, 32'd2, 0, OUT_NOTED, 4},
      '{REQ_NOTICE, 0, 0, 0, 0, 32'hFFFFFFFF, 1, OUT_UNKNOWN, 4},
      '{REQ_TICK, 0, 0, 0, 0, 0, 0, OUT_TICK, 4},
      '{REQ_CLEAR, 0, 0, 0, 0, 0, 1, OUT_CLEARED, 0},
      '{REQ_PEAK, 21'd7, 0, 0, 0, 0, 0, OUT_CREATED, 1}
   };

   initial begin
      tracker_rsp_type p;
      int burst;
      errors = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = '0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      cfg_center = 14035000; cfg_band_lo = 14000000; cfg_band_hi = 14070000;
      cfg_spacing = 100; cfg_limit = 16; cfg_loss = 5; cfg_timeout = 30;
      for (int i = 0; i < MaxSlots; i++) begin
         ch_valid[i] = 0; ch_signal[i] = 0; ch_id[i] = 0;
         ch_center[i] = 0; ch_seen[i] = 0; ch_decode[i] = 0;
      end
      now_s = 0;
      next_chan_id = 1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         send_beat(directed[i].kind, directed[i].freq, directed[i].bin, directed[i].mag,
                   directed[i].snr, directed[i].id, 1'b0, p);
         if (directed[i].known && (p.outcome !== directed[i].outcome ||
                                   p.in_use !== directed[i].in_use)) begin
            $display("%0t: table row %0d expected %0d/%0d actual %0d/%0d", $time, i,
                     directed[i].outcome, directed[i].in_use, p.outcome, p.in_use);
            errors++;
         end
      end
      wait_drained();

      // settings: defaults, tight table with short timers, wide open extremes, narrow band at center 0
      for (int phase = 0; phase < 4; phase++) begin
         if (phase == 1) begin
            write_reg(REG_LIMIT, 32'd3);
            write_reg(REG_LOSS, 32'd0);
            write_reg(REG_TIMEOUT, 32'd2);
            write_reg(REG_SPACING, 32'd1);
         end else if (phase == 2) begin
            write_reg(REG_CENTER, 32'hFFFFFFFF);
            write_reg(REG_BAND_LO, 32'd0);
            write_reg(REG_BAND_HI, 32'hFFFFFFFF);
            write_reg(REG_SPACING, 32'd65535);
            write_reg(REG_LIMIT, 32'd0);
            write_reg(REG_LOSS, 32'd65535);
            write_reg(REG_TIMEOUT, 32'd65535);
         end else if (phase == 3) begin
            write_reg(REG_CENTER, 32'd0);
            write_reg(REG_BAND_HI, 32'd300);
            write_reg(REG_SPACING, 32'd40);
            write_reg(REG_LIMIT, 32'd31);
            write_reg(REG_LOSS, 32'd3);
            write_reg(REG_TIMEOUT, 32'd8);
         end
         for (int n = 0; n < 500;) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst; b++, n++) random_item(b != burst - 1);
            repeat ($urandom_range(0, 30)) @(posedge clock);
            if (n % 200 < 12) wait_drained();
         end
         wait_drained();
      end

      if (errors == 0) $display("[spectral_channel_tracker] OK");
      else $display("[spectral_channel_tracker] ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
sv/sct_pkg.sv
sv/sct_core.sv
sv/spectral_channel_tracker.sv
test/testbench.sv
